// ===== design/hwb_pkg.sv =====
// ----------------------------------------------------------------------------
// hwb_pkg
// Shared types and constants of the histogram white balance block.
// ----------------------------------------------------------------------------
package hwb_pkg;

  localparam int unsigned Bins  = 256;
  localparam int unsigned NChan = 3;

  typedef enum logic [1:0] {
    KIND_COUNT   = 2'd0,
    KIND_END     = 2'd1,
    KIND_CORRECT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

endpackage

// ===== design/histogram_white_balance.sv =====
// ----------------------------------------------------------------------------
// histogram_white_balance
// Per-channel percentile stretch over BGR pixels with three histograms in one shared RAM.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low bit up)                    | tuser
// in_     | in  | blue[7:0] green[15:8] red[23:16]      | kind[1:0]
// out_    | out | blue_out green_out red_out flat_mask  | -
//
// Count: accept, then a read and a write-back of the shared bin word per channel.
// End of statistics: a low scan, a high scan, then a clearing pass of the histogram RAM.
// Correct: accept, the serial divider per channel unless the channel is flat, then output.
// After reset a clearing pass holds in_tready low.
// in_tready is also low while a result waits in the output register under a stall.
module histogram_white_balance #(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue, green, red
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // blue_out, green_out, red_out, flat_mask, zero pad
);

  localparam int unsigned TotW = $clog2(MAX_PIXELS + 1);
  // No bin can exceed the pixel count, so a bin is as wide as the count.
  localparam int unsigned BinW = TotW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CRD   = 9'b000000100,
    S_CWR   = 9'b000001000,
    S_LOW   = 9'b000010000,
    S_HIGH  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_DWAIT = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Histogram memory: one word per bin index holds the three channel bins.
  logic [3*BinW-1:0] mem [hwb_pkg::Bins];
  logic [3*BinW-1:0] rdata_r;
  logic [7:0] raddr, waddr;
  logic       we;
  logic [3*BinW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [TotW-1:0]  total_r, total_nxt;
  logic [7:0]       pix_r [3];
  logic [7:0]       pix_nxt [3];
  logic [7:0]       lo_r [3];
  logic [7:0]       lo_nxt [3];
  logic [7:0]       hi_r [3];
  logic [7:0]       hi_nxt [3];
  logic [8:0]       idx_r, idx_nxt;        // scan index, one ahead of data
  logic [28:0]      cum_r [3];
  logic [28:0]      cum_nxt [3];
  logic [2:0]       lfound_r, lfound_nxt;
  logic [2:0]       hfound_r, hfound_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [7:0]       res_r [3];
  logic [7:0]       res_nxt [3];
  logic [2:0]       mask_r, mask_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [31:0]      odata_r, odata_nxt;

  logic        div_start;
  logic [15:0] div_dend;
  logic [7:0]  div_dvs;
  logic        div_done;
  logic [7:0]  div_q;

  hwb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [33:0] t20, t19;
  logic [7:0]  vc, lo_c, hi_c;
  logic [28:0] csum;
  logic [BinW-1:0] bin;

  assign in_tready = (state_r == S_IDLE) && !(ovalid_r && !out_tready);

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    pix_nxt    = pix_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    cum_nxt    = cum_r;
    lfound_nxt = lfound_r;
    hfound_nxt = hfound_r;
    ch_nxt     = ch_r;
    res_nxt    = res_r;
    mask_nxt   = mask_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    raddr      = idx_r[7:0];
    waddr      = idx_r[7:0];
    we         = 1'b0;
    wdata      = '0;
    div_start  = 1'b0;
    div_dend   = '0;
    div_dvs    = '0;
    vc         = pix_r[ch_r];
    lo_c       = lo_r[ch_r];
    hi_c       = hi_r[ch_r];
    csum       = '0;
    bin        = '0;
    t20        = '0;
    t19        = {5'd0, 29'(total_r)} * 34'd19;
    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        idx_nxt = idx_r + 9'd1;
        if (idx_r == 9'd255) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          pix_nxt[0] = in_tdata[7:0];
          pix_nxt[1] = in_tdata[15:8];
          pix_nxt[2] = in_tdata[23:16];
          unique case (hwb_pkg::kind_t'(in_tuser))
            hwb_pkg::KIND_COUNT: begin
              if (32'(total_r) < MAX_PIXELS) begin
                total_nxt = total_r + TotW'(1);
                ch_nxt    = 2'd0;
                state_nxt = S_CRD;
              end
            end
            hwb_pkg::KIND_END: begin
              idx_nxt    = '0;
              cum_nxt    = '{default: '0};
              lfound_nxt = '0;
              state_nxt  = S_LOW;
            end
            hwb_pkg::KIND_CORRECT: begin
              ch_nxt    = 2'd0;
              mask_nxt  = '0;
              state_nxt = S_DIV;
            end
            default: ;
          endcase
        end
      end
      // Read-modify-write one channel at a time; the word read back carries the
      // earlier channel's update because the write lands before the next read.
      S_CRD: begin
        raddr     = pix_r[ch_r];
        state_nxt = S_CWR;
      end
      S_CWR: begin
        waddr = pix_r[ch_r];
        we    = 1'b1;
        wdata = rdata_r;
        unique case (ch_r)
          2'd0: wdata[BinW-1:0] = rdata_r[BinW-1:0] + 1'b1;
          2'd1: wdata[2*BinW-1:BinW] = rdata_r[2*BinW-1:BinW] + 1'b1;
          default: wdata[3*BinW-1:2*BinW] = rdata_r[3*BinW-1:2*BinW] + 1'b1;
        endcase
        if (ch_r == 2'd2) state_nxt = S_IDLE;
        else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_CRD;
        end
      end
      // Low search: bin idx_r-1 data arrives while idx_r is being read.
      S_LOW: begin
        idx_nxt = idx_r + 9'd1;
        if (idx_r != 9'd0) begin
          for (int c = 0; c < 3; c++) begin
            bin        = rdata_r[c*BinW +: BinW];
            csum       = cum_r[c] + 29'(bin);
            cum_nxt[c] = csum;
            t20        = {5'd0, csum} * 34'd20;
            if (!lfound_r[c] && (t20 >= 34'(total_r) || idx_r == 9'd256)) begin
              lfound_nxt[c] = 1'b1;
              lo_nxt[c]     = 8'(idx_r - 9'd1);
            end
          end
        end
        if (idx_r == 9'd256) begin
          // Full sums known: hi search walks down from bin 255 subtracting bins.
          idx_nxt    = 9'd255;
          hfound_nxt = '0;
          raddr      = 8'd255;
          state_nxt  = S_HIGH;
        end
      end
      // cum_r holds C(j) for j = idx_r; the read of bin j returns now.
      S_HIGH: begin
        raddr = 8'(idx_r - 9'd1);
        for (int c = 0; c < 3; c++) begin
          t20 = {5'd0, cum_r[c]} * 34'd20;
          if (!hfound_r[c] && (t20 <= t19 || idx_r == 9'd0)) begin
            hfound_nxt[c] = 1'b1;
            hi_nxt[c]     = (idx_r < 9'd254) ? 8'(idx_r + 9'd1) : idx_r[7:0];
          end
          cum_nxt[c] = cum_r[c] - 29'(rdata_r[c*BinW +: BinW]);
        end
        idx_nxt = idx_r - 9'd1;
        if (idx_r == 9'd0) begin
          idx_nxt   = '0;
          total_nxt = '0;
          state_nxt = S_CLEAR;
        end
      end
      S_DIV: begin
        if (vc < lo_c) vc = lo_c;
        if (vc > hi_c) vc = hi_c;
        if (hi_c <= lo_c) begin
          mask_nxt[ch_r] = 1'b1;
          res_nxt[ch_r]  = '0;
          if (ch_r == 2'd2) state_nxt = S_OUT;
          else ch_nxt = ch_r + 2'd1;
        end else begin
          div_start = 1'b1;
          div_dend  = 16'((vc - lo_c) * 16'd255);
          div_dvs   = hi_c - lo_c;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          res_nxt[ch_r] = div_q;
          if (ch_r == 2'd2) state_nxt = S_OUT;
          else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_DIV;
          end
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {5'd0, mask_r, res_r[2], res_r[1], res_r[0]};
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      idx_r    <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
      lo_r     <= '{default: 8'd0};
      hi_r     <= '{default: 8'd255};
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
    end
    pix_r    <= pix_nxt;
    cum_r    <= cum_nxt;
    lfound_r <= lfound_nxt;
    hfound_r <= hfound_nxt;
    ch_r     <= ch_nxt;
    res_r    <= res_nxt;
    mask_r   <= mask_nxt;
    odata_r  <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// ===== design/hwb_div.sv =====
// ----------------------------------------------------------------------------
// hwb_div
// Restoring divider, one quotient bit per cycle: 16-bit dividend by 8-bit divisor.
// ----------------------------------------------------------------------------
module hwb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [7:0]  quotient
);

  logic [15:0] q_r, q_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[15]} - {2'b00, dvs_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[9]) begin
        rem_nxt = trial[8:0];
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[7:0], q_r[15]};
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[7:0];

endmodule

// ===== sim/histogram_white_balance_tb.sv =====
// ----------------------------------------------------------------------------
// histogram_white_balance_tb
// Drives counting, end-of-statistics and correction transfers into the white
// balance block and compares every corrected pixel with a behavioral
// predictor of the percentile stretch, under varying idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class balance_scoreboard;
  int unsigned bin_count[3][256];
  int unsigned pixel_count;
  int unsigned max_pixels;
  bit [7:0] lo_lim[3];
  bit [7:0] hi_lim[3];
  bit [26:0] pending_pixels[$];
  int unsigned mismatches;

  function new(int unsigned max_px);
    max_pixels = max_px;
    pixel_count = 0;
    mismatches = 0;
    foreach (bin_count[c, j]) bin_count[c][j] = 0;
    for (int c = 0; c < 3; c++) begin
      lo_lim[c] = 8'd0;
      hi_lim[c] = 8'd255;
    end
  endfunction

  function void set_limits();
    longint unsigned cum[256];
    longint unsigned run;
    longint unsigned t;
    int lo;
    int hi;
    t = pixel_count;
    for (int c = 0; c < 3; c++) begin
      run = 0;
      for (int j = 0; j < 256; j++) begin
        run += bin_count[c][j];
        cum[j] = run;
      end
      lo = 0;
      while (lo < 255 && cum[lo] * 20 < t) lo++;
      hi = 255;
      while (hi > 0 && cum[hi] * 20 > t * 19) hi--;
      if (hi < 254) hi++;
      lo_lim[c] = lo[7:0];
      hi_lim[c] = hi[7:0];
    end
    foreach (bin_count[c, j]) bin_count[c][j] = 0;
    pixel_count = 0;
  endfunction

  // Notes one accepted input transfer.
  function void note_input(hwb_pkg::kind_t kind, bit [23:0] pix);
    bit [7:0] v;
    bit [26:0] res;
    int unsigned r;
    case (kind)
      hwb_pkg::KIND_COUNT: begin
        if (pixel_count < max_pixels) begin
          for (int c = 0; c < 3; c++) bin_count[c][pix[c*8 +: 8]]++;
          pixel_count++;
        end
      end
      hwb_pkg::KIND_END: set_limits();
      hwb_pkg::KIND_CORRECT: begin
        res = '0;
        for (int c = 0; c < 3; c++) begin
          v = pix[c*8 +: 8];
          if (v < lo_lim[c]) v = lo_lim[c];
          if (v > hi_lim[c]) v = hi_lim[c];
          if (hi_lim[c] <= lo_lim[c]) begin
            res[24 + c] = 1'b1;
          end else begin
            r = ((v - lo_lim[c]) * 255) / (hi_lim[c] - lo_lim[c]);
            res[c*8 +: 8] = r[7:0];
          end
        end
        pending_pixels.insert(pending_pixels.size(), res);
      end
      default: ;
    endcase
  endfunction

  function void check_result(bit [31:0] data);
    bit [26:0] exp_px;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", data);
      return;
    end
    exp_px = pending_pixels.pop_front();
    if (data[7:0] !== exp_px[7:0] || data[15:8] !== exp_px[15:8] ||
        data[23:16] !== exp_px[23:16] || data[26:24] !== exp_px[26:24]) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected b=%0d g=%0d r=%0d flat=%b, ",
                  "got b=%0d g=%0d r=%0d flat=%b"},
                 exp_px[7:0], exp_px[15:8], exp_px[23:16], exp_px[26:24],
                 data[7:0], data[15:8], data[23:16], data[26:24]);
    end
  endfunction
endclass

module histogram_white_balance_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;

  balance_scoreboard board;

  histogram_white_balance i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("histogram_white_balance_tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One transfer; gaps are taken before valid is raised.
  task automatic send_item(hwb_pkg::kind_t kind, bit [23:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    board.note_input(kind, pix);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (900) @(posedge clk);
  endtask

  // Sensible frame: counts around a random center and spread, an end of statistics, then corrections.
  task automatic send_frame(int unsigned n_count, int unsigned n_corr);
    int unsigned ctr[3];
    int unsigned spread[3];
    bit [23:0] pix;
    int v;
    for (int c = 0; c < 3; c++) begin
      ctr[c] = $urandom_range(255);
      spread[c] = $urandom_range(128);
    end
    for (int i = 0; i < n_count; i++) begin
      for (int c = 0; c < 3; c++) begin
        v = int'(ctr[c]) + int'($urandom_range(2 * spread[c])) - int'(spread[c]);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        pix[c*8 +: 8] = v[7:0];
      end
      if ($urandom_range(19) == 0) pix = 24'($urandom);
      send_item(($urandom_range(40) == 0) ? hwb_pkg::KIND_NONE : hwb_pkg::KIND_COUNT, pix);
    end
    send_item(hwb_pkg::KIND_END, 24'($urandom));
    for (int i = 0; i < n_corr; i++) send_item(hwb_pkg::KIND_CORRECT, 24'($urandom));
  endtask

  initial begin
    board = new(1048576);
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = hwb_pkg::KIND_NONE;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limits, empty statistics, extremes, unused kind, flat channels.
    send_item(hwb_pkg::KIND_CORRECT, 24'h000000);
    send_item(hwb_pkg::KIND_CORRECT, 24'hFFFFFF);
    send_item(hwb_pkg::KIND_CORRECT, 24'h80FF01);
    send_item(hwb_pkg::KIND_NONE, 24'hFFFFFF);
    send_item(hwb_pkg::KIND_END, 24'hFFFFFF);
    send_item(hwb_pkg::KIND_CORRECT, 24'h7F00FF);
    for (int i = 0; i < 6; i++) send_item(hwb_pkg::KIND_COUNT, 24'hFF0080);
    send_item(hwb_pkg::KIND_END, 24'h000000);
    send_item(hwb_pkg::KIND_CORRECT, 24'h000000);
    send_item(hwb_pkg::KIND_CORRECT, 24'hFFFFFF);
    send_item(hwb_pkg::KIND_CORRECT, 24'h55AA80);
    send_item(hwb_pkg::KIND_COUNT, 24'h000000);
    send_item(hwb_pkg::KIND_COUNT, 24'hFFFFFF);
    send_item(hwb_pkg::KIND_COUNT, 24'h00FF00);
    send_item(hwb_pkg::KIND_END, 24'h000000);
    send_item(hwb_pkg::KIND_CORRECT, 24'hFF00FF);
    send_item(hwb_pkg::KIND_CORRECT, 24'h7F7F7F);
    drain();

    // Random phases over the idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 87 : 26) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 87 : 26) : 0;
      for (int f = 0; f < 5; f++)
        send_frame($urandom_range(25, 70), $urandom_range(10, 25));
      // Sender pauses until every expected result has come.
      in_tvalid <= 1'b0;
      while (board.pending_pixels.size() != 0) @(posedge clk);
    end

    // Long receiver hold-off while corrections keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_frame(30, 0);
    hold_off_cycles = 2000;
    for (int i = 0; i < 20; i++) send_item(hwb_pkg::KIND_CORRECT, 24'($urandom));

    drain();
    if (board.mismatches == 0) begin
      $display("histogram_white_balance_tb: PASS");
    end else begin
      $display("histogram_white_balance_tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== histogram_white_balance.f =====
design/hwb_pkg.sv
design/hwb_div.sv
design/histogram_white_balance.sv
sim/histogram_white_balance_tb.sv
